// ===== src/pwe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwe_pkg
// shared types, codes and constant tables of the exp envelope evaluator
// ----------------------------------------------------------------------------
package pwe_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;
  localparam int FixW      = 32;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // register indexes
  localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
  localparam logic [1:0] REG_MODE_ABSCISSA = 2'd1;
  localparam logic [1:0] REG_MODE_SIDE     = 2'd2;
  localparam logic [1:0] REG_MODE_INTERIOR = 2'd3;

  // envelope cases
  localparam logic [2:0] CASE_RIGHT_CONST  = 3'd0;
  localparam logic [2:0] CASE_LEFT_SECANT  = 3'd1;
  localparam logic [2:0] CASE_RIGHT_SECANT = 3'd2;
  localparam logic [2:0] CASE_LEFT_CONST   = 3'd3;
  localparam logic [2:0] CASE_NONE         = 3'd4;

  // log2(e) in q16
  localparam logic signed [18:0] LOG2E_Q16 = 19'sd94548;
  // exponent clamp, 32.0 in q16.16
  localparam logic signed [50:0] X_LIMIT = 51'sd2097152;

  typedef struct packed {
    logic [CntW-1:0]        point_count;
    logic signed [FixW-1:0] mode_abscissa;
    logic                   mode_side;
    logic                   mode_interior;
  } cfg_t;

  typedef struct packed {
    logic [FixW-1:0] value;
    logic [2:0]      case_taken;
    logic            saturated;
  } res_t;

  typedef logic [31:0] root_tab_t [0:16];

  // t[k] = isqrt(t[k-1] * 2^30), t[0] = 2^31
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bitv;
    t[0] = 32'h8000_0000;
    for (int k = 1; k <= 16; k++) begin
      a    = {2'b00, t[k-1], 30'b0};
      res  = 64'd0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        if (a >= res + bitv) begin
          a   = a - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      t[k] = res[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

  // clamp a wide log value into the exponent range [-32, 32]
  function automatic logic signed [22:0] clamp_x(input logic signed [50:0] v);
    logic signed [50:0] c;
    c = v;
    if (v > X_LIMIT) c = X_LIMIT;
    if (v < -X_LIMIT) c = -X_LIMIT;
    return c[22:0];
  endfunction

endpackage

// ===== src/pwe_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwe_store
// point table: abscissa and log value per row, one write and one read port
// ----------------------------------------------------------------------------
module pwe_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [pwe_pkg::IdxW-1:0]  wr_addr,
  input  logic [2*pwe_pkg::FixW-1:0] wr_data,
  input  logic [pwe_pkg::IdxW-1:0]  rd_addr,
  output logic [2*pwe_pkg::FixW-1:0] rd_data
);

  logic [2*pwe_pkg::FixW-1:0] mem [0:pwe_pkg::MaxPoints-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/pwe_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwe_core
// sequencer and shared iterative datapath: search, divide, multiply, exp
// ----------------------------------------------------------------------------
module pwe_core (
  input  logic                        clk,
  input  logic                        rst,
  input  pwe_pkg::cfg_t               cfg,
  input  logic                        start,
  input  logic signed [pwe_pkg::FixW-1:0] query,
  output logic [pwe_pkg::IdxW-1:0]    rd_addr,
  input  logic [2*pwe_pkg::FixW-1:0]  rd_data,
  output logic                        busy,
  output logic                        res_valid,
  input  logic                        res_take,
  output pwe_pkg::res_t               res
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_SRCH_RD  = 15'b000000000000010,
    S_SRCH_CMP = 15'b000000000000100,
    S_FET_RD   = 15'b000000000001000,
    S_FET_CAP  = 15'b000000000010000,
    S_DECIDE   = 15'b000000000100000,
    S_SEC      = 15'b000000001000000,
    S_DIV      = 15'b000000010000000,
    S_SLOPE    = 15'b000000100000000,
    S_MUL      = 15'b000001000000000,
    S_LOG      = 15'b000010000000000,
    S_EXP_Y    = 15'b000100000000000,
    S_EXP_R    = 15'b001000000000000,
    S_EXP_SH   = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  localparam int W  = pwe_pkg::FixW;
  localparam int IW = pwe_pkg::IdxW;
  localparam int CW = pwe_pkg::CntW;

  state_t state;

  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_m1;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       s;
  logic signed [W-1:0] q;
  logic [1:0]          fk;
  logic signed [W-1:0] row_abs [0:3];
  logic signed [W-1:0] row_log [0:3];
  logic [2:0]          cs;
  logic [IW-1:0]       im1;
  logic [IW-1:0]       ip1;
  logic [IW-1:0]       ip2;
  logic [IW-1:0]       fetch_addr;
  logic signed [W-1:0] rd_abs;
  logic signed [W-1:0] rd_log;

  // divider / multiplier / exp registers
  logic        neg;
  logic [32:0] den;
  logic [32:0] rem;
  logic [48:0] quo;
  logic [5:0]  step;
  logic [31:0] mcand;
  logic [65:0] prod;
  logic signed [22:0] x;
  logic signed [7:0]  n;
  logic [15:0] f;
  logic [30:0] r;
  logic [3:0]  j;
  logic        anchor_hi;

  assign rd_abs = signed'(rd_data[2*W-1:W]);
  assign rd_log = signed'(rd_data[W-1:0]);

  always_comb begin
    cnt = cfg.point_count;
    if (cfg.point_count < CW'(2)) cnt = CW'(2);
    if (cfg.point_count > CW'(pwe_pkg::MaxPoints)) cnt = CW'(pwe_pkg::MaxPoints);
  end
  assign cnt_m1 = cnt - CW'(1);

  assign im1 = (s != '0) ? s - IW'(1) : '0;
  assign ip1 = ({1'b0, s} + CW'(1) < cnt) ? s + IW'(1) : cnt_m1[IW-1:0];
  assign ip2 = ({1'b0, s} + CW'(2) < cnt) ? s + IW'(2) : cnt_m1[IW-1:0];

  always_comb begin
    unique case (fk)
      2'd0: fetch_addr = im1;
      2'd1: fetch_addr = s;
      2'd2: fetch_addr = ip1;
      default: fetch_addr = ip2;
    endcase
  end

  assign rd_addr = (state == S_SRCH_RD) ? idx : fetch_addr;

  // case selection from s and its right neighbour
  logic [2:0] cs_next;
  logic signed [W-1:0] a0;
  logic signed [W-1:0] a1;
  logic signed [W-1:0] z;
  assign a0 = row_abs[1];
  assign a1 = row_abs[2];
  assign z  = cfg.mode_abscissa;

  always_comb begin
    priority if ((a1 == z && !cfg.mode_side) || a1 < z) begin
      cs_next = pwe_pkg::CASE_RIGHT_CONST;
    end else if (a1 == z && cfg.mode_side && cfg.mode_interior) begin
      cs_next = pwe_pkg::CASE_LEFT_SECANT;
    end else if (a0 == z && !cfg.mode_side && cfg.mode_interior) begin
      cs_next = pwe_pkg::CASE_RIGHT_SECANT;
    end else if ((a0 == z && cfg.mode_side) || (a1 == z && cfg.mode_side) ||
                 (a0 == z && !cfg.mode_interior) || a0 > z) begin
      cs_next = pwe_pkg::CASE_LEFT_CONST;
    end else begin
      cs_next = pwe_pkg::CASE_NONE;
    end
  end

  // secant operands: rows m1,s for left secant, rows p1,p2 for right secant
  logic signed [32:0] dl;
  logic signed [32:0] da;
  logic signed [W-1:0] anc_abs;
  logic signed [W-1:0] anc_log;
  always_comb begin
    if (anchor_hi) begin
      dl = 33'(row_log[3]) - 33'(row_log[2]);
      da = 33'(row_abs[3]) - 33'(row_abs[2]);
      anc_abs = row_abs[2];
      anc_log = row_log[2];
    end else begin
      dl = 33'(row_log[1]) - 33'(row_log[0]);
      da = 33'(row_abs[1]) - 33'(row_abs[0]);
      anc_abs = row_abs[1];
      anc_log = row_log[1];
    end
  end

  logic [32:0] dl_mag;
  logic [32:0] da_mag;
  assign dl_mag = dl[32] ? 33'(-dl) : 33'(dl);
  assign da_mag = da[32] ? 33'(-da) : 33'(da);

  // restoring divide step
  logic [33:0] rem_sh;
  logic        q_bit;
  logic [33:0] rem_sub;
  assign rem_sh  = {rem, quo[48]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign q_bit   = (rem_sh >= {1'b0, den});

  // slope magnitude after saturation
  logic [31:0] slope_mag;
  always_comb begin
    if (neg) slope_mag = (quo > 49'h0_8000_0000) ? 32'h8000_0000 : quo[31:0];
    else     slope_mag = (quo > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
  end

  logic signed [32:0] dq;
  logic [32:0]        dq_mag;
  assign dq     = 33'(q) - 33'(anc_abs);
  assign dq_mag = dq[32] ? 33'(-dq) : 33'(dq);

  // shift-add multiply step
  logic [32:0] mul_sum;
  assign mul_sum = prod[65:33] + (prod[0] ? {1'b0, mcand} : 33'd0);

  // log value of the secant
  logic signed [65:0] prod_s;
  logic signed [49:0] prod_f;
  logic signed [50:0] lg;
  assign prod_s = neg ? -signed'(prod) : signed'(prod);
  assign prod_f = 50'(prod_s >>> 16);
  assign lg     = 51'(prod_f) + 51'(anc_log);

  // exponent split
  logic signed [41:0] ymul;
  logic signed [25:0] y;
  assign ymul = 42'(x) * 42'(pwe_pkg::LOG2E_Q16);
  assign y    = 26'(ymul >>> 16);

  // fraction multiply
  logic [4:0]  tk;
  logic [62:0] rmul;
  assign tk   = 5'd16 - {1'b0, j};
  assign rmul = {32'd0, r} * {31'd0, pwe_pkg::ROOT_TAB[tk]};

  // final scaling by 2^(n-14)
  logic signed [8:0] sh;
  logic [63:0]       shl;
  logic [30:0]       shr;
  assign sh  = 9'(n) - 9'sd14;
  assign shl = {33'd0, r} << sh[5:0];
  assign shr = r >> 5'(-sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            q     <= query;
            idx   <= '0;
            s     <= '0;
            state <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: state <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          if (rd_abs < q) s <= idx;
          if ({1'b0, idx} == cnt_m1) begin
            fk    <= 2'd0;
            state <= S_FET_RD;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_SRCH_RD;
          end
        end
        S_FET_RD: state <= S_FET_CAP;
        S_FET_CAP: begin
          row_abs[fk] <= rd_abs;
          row_log[fk] <= rd_log;
          fk          <= fk + 2'd1;
          state       <= (fk == 2'd3) ? S_DECIDE : S_FET_RD;
        end
        S_DECIDE: begin
          cs        <= cs_next;
          anchor_hi <= (cs_next == pwe_pkg::CASE_RIGHT_SECANT);
          unique case (cs_next)
            pwe_pkg::CASE_RIGHT_CONST: begin
              x     <= pwe_pkg::clamp_x(51'(row_log[2]));
              state <= S_EXP_Y;
            end
            pwe_pkg::CASE_LEFT_CONST: begin
              x     <= pwe_pkg::clamp_x(51'(row_log[1]));
              state <= S_EXP_Y;
            end
            pwe_pkg::CASE_LEFT_SECANT, pwe_pkg::CASE_RIGHT_SECANT: state <= S_SEC;
            default: begin
              res   <= '{value: '0, case_taken: pwe_pkg::CASE_NONE, saturated: 1'b0};
              state <= S_DONE;
            end
          endcase
        end
        S_SEC: begin
          neg  <= dl[32] ^ da[32];
          den  <= da_mag;
          rem  <= '0;
          // equal abscissae give a flat secant
          quo  <= (da == '0) ? 49'd0 : {dl_mag[32:0], 16'd0};
          step <= 6'd48;
          state <= (da == '0) ? S_SLOPE : S_DIV;
        end
        S_DIV: begin
          rem  <= q_bit ? rem_sub[32:0] : rem_sh[32:0];
          quo  <= {quo[47:0], q_bit};
          step <= step - 6'd1;
          if (step == '0) state <= S_SLOPE;
        end
        S_SLOPE: begin
          mcand <= slope_mag;
          neg   <= neg ^ dq[32];
          prod  <= {33'd0, dq_mag};
          step  <= 6'd32;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= {1'b0, mul_sum, prod[32:1]};
          step  <= step - 6'd1;
          if (step == '0) state <= S_LOG;
        end
        S_LOG: begin
          x     <= pwe_pkg::clamp_x(lg);
          state <= S_EXP_Y;
        end
        S_EXP_Y: begin
          n     <= 8'(y >>> 16);
          f     <= y[15:0];
          r     <= 31'h4000_0000;
          j     <= 4'd15;
          state <= S_EXP_R;
        end
        S_EXP_R: begin
          if (f[j]) r <= rmul[60:30];
          j <= j - 4'd1;
          if (j == '0) state <= S_EXP_SH;
        end
        S_EXP_SH: begin
          res.case_taken <= cs;
          if (!sh[8]) begin
            if (shl[63:32] != '0) begin
              res.value     <= '1;
              res.saturated <= 1'b1;
            end else begin
              res.value     <= shl[31:0];
              res.saturated <= 1'b0;
            end
          end else begin
            res.value     <= (sh < -9'sd31) ? '0 : {1'b0, shr};
            res.saturated <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  cs_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.case_taken <= pwe_pkg::CASE_NONE)
    else $error("case code out of range");
  none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.case_taken == pwe_pkg::CASE_NONE |-> res.value == '0 && !res.saturated)
    else $error("no-envelope case gives nonzero value");
  sat_max: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.saturated |-> &res.value)
    else $error("saturated result not clamped to full scale");

endmodule

// ===== src/piecewise_exp_envelope_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_exp_envelope_eval
// piecewise exponential envelope over a loaded table of sorted points
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall; operation load writes one table row
//   (point_index, abscissa_value, log_value) and is done in the accept cycle;
//   operation eval takes query_point and yields one output word
// output channel: out_valid / out_stall carries envelope_value, case_taken
//   and saturated; a registered output stage holds the word while stalled,
//   and the block takes the next input word meanwhile
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   point_count, mode_abscissa, mode_side or mode_interior
// steps of an eval word, accept to out_valid:
//   search over the cnt rows, fetch of four rows, decide, then
//   constant cases: exp (one multiply, a step per fraction bit, scale)
//   secant cases: setup, divide (skipped for equal abscissae), slope, multiply, log, exp;
//   the bit-serial divider and shift-add multiplier of the shared core
//   set the long path
// in_stall is high for the whole evaluation; no new word enters meanwhile
// reset clears control and config; table rows stay undefined until loaded
// ----------------------------------------------------------------------------
module piecewise_exp_envelope_eval (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [3:0]  point_index,
  input  logic signed [31:0] abscissa_value,
  input  logic signed [31:0] log_value,
  input  logic signed [31:0] query_point,
  // output words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] envelope_value,
  output logic [2:0]  case_taken,
  output logic        saturated,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pwe_pkg::cfg_t cfg;
  pwe_pkg::res_t res;
  logic          busy;
  logic          res_valid;
  logic          res_take;
  logic          accept;
  logic [3:0]    rd_addr;
  logic [63:0]   rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{point_count: 5'd2, mode_abscissa: '0, mode_side: 1'b0, mode_interior: 1'b0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwe_pkg::REG_POINT_COUNT:   cfg.point_count   <= cfg_data[4:0];
        pwe_pkg::REG_MODE_ABSCISSA: cfg.mode_abscissa <= signed'(cfg_data);
        pwe_pkg::REG_MODE_SIDE:     cfg.mode_side     <= cfg_data[0];
        pwe_pkg::REG_MODE_INTERIOR: cfg.mode_interior <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // table rows are written straight from an accepted load word
  pwe_store u_store (
    .clk     (clk),
    .wr_en   (accept && operation == pwe_pkg::OP_LOAD),
    .wr_addr (point_index),
    .wr_data ({abscissa_value, log_value}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pwe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (accept && operation == pwe_pkg::OP_EVAL),
    .query     (query_point),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      envelope_value <= res.value;
      case_taken     <= res.case_taken;
      saturated      <= res.saturated;
    end
  end

  eval_blocks: assert property (@(posedge clk) disable iff (rst)
    accept && operation == pwe_pkg::OP_EVAL |=> in_stall)
    else $error("eval word accepted without going busy");
  load_free: assert property (@(posedge clk) disable iff (rst)
    accept && operation == pwe_pkg::OP_LOAD |=> !in_stall)
    else $error("load word left the block busy");
  sat_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> &envelope_value)
    else $error("saturated word not at full scale");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the piecewise exp envelope evaluator
// ----------------------------------------------------------------------------
// loads mostly sorted or noise tables, moves the mode and side/interior flags
// between phases, checks each evaluate word against an in-bench predictor or
// a typed result; idling and stalling vary by phase, with a long output hold
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LatCycles = 2 * 16 + 113 + 16;  // slowest eval plus margin
  localparam int CycleLimit = 1500000;
  localparam int ItemTarget = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = pwe_pkg::OP_LOAD;
  logic [3:0]  point_index = '0;
  logic signed [31:0] abscissa_value = '0;
  logic signed [31:0] log_value = '0;
  logic signed [31:0] query_point = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] envelope_value;
  logic [2:0]  case_taken;
  logic        saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  piecewise_exp_envelope_eval i_dut (
    .clk, .rst,
    .in_valid, .in_stall, .operation, .point_index, .abscissa_value, .log_value,
    .query_point,
    .out_valid, .out_stall, .envelope_value, .case_taken, .saturated,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state: table, registers and the q30 root table
  longint          abs_tab [16];
  longint          log_tab [16];
  logic [4:0]      cnt_reg;
  longint          mode_z;
  bit              side_reg;
  bit              inter_reg;
  longint unsigned roots [17];

  pwe_pkg::res_t envelope_q[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_cycles = 0;

  function automatic longint unsigned sqrt_floor(longint unsigned a);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= res + b) begin
        a = a - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // exp of a q16.16 log value into unsigned q16.16, saturating
  function automatic void exp_q16(input longint x, output logic [31:0] v, output logic sat);
    longint y, n, f, sh;
    longint unsigned r, w;
    if (x > 32 * 65536) x = 32 * 65536;
    if (x < -32 * 65536) x = -32 * 65536;
    y = (x * 94548) >>> 16;
    n = y >>> 16;
    f = y - n * 65536;
    r = 64'd1 << 30;
    for (int j = 15; j >= 0; j--)
      if (f[j]) r = (r * roots[16-j]) >> 30;
    sat = 1'b0;
    sh = n - 14;
    if (sh >= 33) w = 64'h1_0000_0000;
    else if (sh >= 0) w = r << sh;
    else if (-sh > 31) w = 0;
    else w = r >> (-sh);
    if (w > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      w = 64'hFFFF_FFFF;
    end
    v = w[31:0];
  endfunction

  function automatic longint secant_log(int i0, int i1, int anchor, longint q);
    longint dl, da, slope;
    dl = log_tab[i1] - log_tab[i0];
    da = abs_tab[i1] - abs_tab[i0];
    slope = 0;
    if (da != 0) begin
      slope = (dl * 65536) / da;
      if (slope > 64'sd2147483647) slope = 64'sd2147483647;
      if (slope < -64'sd2147483648) slope = -64'sd2147483648;
    end
    return log_tab[anchor] + ((slope * (q - abs_tab[anchor])) >>> 16);
  endfunction

  function automatic pwe_pkg::res_t envelope_at(longint q);
    pwe_pkg::res_t rs;
    int     cnt, s, im1, ip1, ip2;
    longint a0, a1, lg;
    cnt = cnt_reg;
    if (cnt < 2) cnt = 2;
    if (cnt > 16) cnt = 16;
    s = 0;
    for (int i = 0; i < cnt; i++)
      if (abs_tab[i] < q) s = i;
    im1 = s > 0 ? s - 1 : 0;
    ip1 = s + 1 < cnt ? s + 1 : cnt - 1;
    ip2 = s + 2 < cnt ? s + 2 : cnt - 1;
    a0 = abs_tab[s];
    a1 = abs_tab[ip1];
    lg = 0;
    if ((a1 == mode_z && !side_reg) || a1 < mode_z) begin
      rs.case_taken = pwe_pkg::CASE_RIGHT_CONST;
      lg = log_tab[ip1];
    end else if (a1 == mode_z && side_reg && inter_reg) begin
      rs.case_taken = pwe_pkg::CASE_LEFT_SECANT;
      lg = secant_log(im1, s, s, q);
    end else if (a0 == mode_z && !side_reg && inter_reg) begin
      rs.case_taken = pwe_pkg::CASE_RIGHT_SECANT;
      lg = secant_log(ip1, ip2, ip1, q);
    end else if ((a0 == mode_z && side_reg) || (a1 == mode_z && side_reg && !inter_reg) ||
                 (a0 == mode_z && !side_reg && !inter_reg) || a0 > mode_z) begin
      rs.case_taken = pwe_pkg::CASE_LEFT_CONST;
      lg = log_tab[s];
    end else begin
      rs.case_taken = pwe_pkg::CASE_NONE;
    end
    if (rs.case_taken == pwe_pkg::CASE_NONE) begin
      rs.value = '0;
      rs.saturated = 1'b0;
    end else begin
      exp_q16(lg, rs.value, rs.saturated);
    end
    return rs;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL piecewise_exp_envelope_eval");
      $finish;
    end
  end

  // output side: stall pattern and long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      out_stall <= 1'b1;
      hold_cycles <= 599;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    pwe_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (envelope_q.size() == 0) begin
        $error("unexpected result word: value %h case %0d sat %0d",
               envelope_value, case_taken, saturated);
        errors++;
      end else begin
        want = envelope_q.pop_front();
        if (envelope_value !== want.value) begin
          $error("envelope_value expected %h actual %h", want.value, envelope_value);
          errors++;
        end
        if (case_taken !== want.case_taken) begin
          $error("case_taken expected %0d actual %0d", want.case_taken, case_taken);
          errors++;
        end
        if (saturated !== want.saturated) begin
          $error("saturated expected %0d actual %0d", want.saturated, saturated);
          errors++;
        end
      end
    end
  end

  // one input word; predicts on acceptance, unless a typed result is given
  task automatic send_word(logic op, logic [3:0] idx, logic [31:0] absc, logic [31:0] lv,
                           logic [31:0] qry, bit typed = 0,
                           pwe_pkg::res_t typed_res = '0);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    operation      <= op;
    point_index    <= idx;
    abscissa_value <= absc;
    log_value      <= lv;
    query_point    <= qry;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (op == pwe_pkg::OP_LOAD) begin
      abs_tab[idx] = longint'(signed'(absc));
      log_tab[idx] = longint'(signed'(lv));
    end else if (typed) begin
      envelope_q.push_back(typed_res);
    end else begin
      envelope_q.push_back(envelope_at(longint'(signed'(qry))));
    end
  endtask

  task automatic in_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for every expected word, then let a possible eval in flight finish
  task automatic drain();
    while (envelope_q.size() != 0) @(posedge clk);
    repeat (LatCycles) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pwe_pkg::REG_POINT_COUNT:   cnt_reg = data[4:0];
      pwe_pkg::REG_MODE_ABSCISSA: mode_z = longint'(signed'(data));
      pwe_pkg::REG_MODE_SIDE:     side_reg = data[0];
      pwe_pkg::REG_MODE_INTERIOR: inter_reg = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // directed rows: unit-spaced table, extremes of log value and query
  typedef struct {
    logic          op;
    logic [3:0]    idx;
    logic [31:0]   absc;
    logic [31:0]   lv;
    logic [31:0]   qry;
    bit            typed;
    pwe_pkg::res_t res;
  } row_t;

  row_t directed [$];

  initial begin
    longint plan_abs [16];
    longint plan_log [16];
    longint acc;
    int     sent, phase, n_eval, k, pc;
    logic [31:0] qv, mz;
    row_t   r;

    roots[0] = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) roots[i] = sqrt_floor(roots[i-1] << 30);
    foreach (abs_tab[i]) begin
      abs_tab[i] = 0;
      log_tab[i] = 0;
    end
    cnt_reg = 2;
    mode_z = 0;
    side_reg = 0;
    inter_reg = 0;

    // abscissa k at k*1.0; slot 0 log max, slot 1 log min
    for (int i = 0; i < 16; i++) begin
      r = '{pwe_pkg::OP_LOAD, 4'(i), 32'(i * 65536), 32'(i * 20000 - 150000), 32'h0,
            0, '0};
      if (i == 0) r.lv = 32'h7FFF_FFFF;
      if (i == 1) r.lv = 32'h8000_0000;
      directed.push_back(r);
    end
    // default config: mode at slot 0, side 0, not interior -> left constant
    directed.push_back('{pwe_pkg::OP_EVAL, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_0000, 1,
                         '{32'hFFFF_FFFF, pwe_pkg::CASE_LEFT_CONST, 1'b1}});
    directed.push_back('{pwe_pkg::OP_EVAL, 4'h0, 32'h0, 32'h0, 32'h8000_0000, 1,
                         '{32'hFFFF_FFFF, pwe_pkg::CASE_LEFT_CONST, 1'b1}});
    directed.push_back('{pwe_pkg::OP_EVAL, 4'h0, 32'h0, 32'h0, 32'h0000_8000, 1,
                         '{32'hFFFF_FFFF, pwe_pkg::CASE_LEFT_CONST, 1'b1}});
    directed.push_back('{pwe_pkg::OP_EVAL, 4'h5, 32'h0, 32'h0, 32'h7FFF_FFFF, 1,
                         '{32'h0, pwe_pkg::CASE_LEFT_CONST, 1'b0}});
    directed.push_back('{pwe_pkg::OP_EVAL, 4'h0, 32'h0, 32'h0, 32'h0001_0001, 0, '0});
    directed.push_back('{pwe_pkg::OP_EVAL, 4'h0, 32'h0, 32'h0, 32'h0001_0000, 0, '0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_word(directed[i].op, directed[i].idx, directed[i].absc, directed[i].lv,
                directed[i].qry, directed[i].typed, directed[i].res);
    in_quiet();
    foreach (plan_abs[i]) begin
      plan_abs[i] = abs_tab[i];
      plan_log[i] = log_tab[i];
    end

    sent = 0;
    phase = 0;
    while (sent < ItemTarget) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase

      // new table: mostly sorted with random spacing, sometimes plain noise or kept
      k = $urandom_range(99);
      if (phase == 0 || k < 60) begin
        acc = (k < 10) ? -64'sd2147483648 : longint'(signed'(rand_word())) >>> 2;
        for (int i = 0; i < 16; i++) begin
          plan_abs[i] = acc;
          case ($urandom_range(3))
            0: acc = acc;                                   // duplicate abscissa
            1: acc = acc + $urandom_range(1, 4);
            2: acc = acc + $urandom_range(1, 8 * 65536);
            default: acc = acc + $urandom_range(1, 32'h1000_0000);
          endcase
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if ($urandom_range(15) == 0)
            plan_log[i] = longint'(signed'(rand_word()));
          else
            plan_log[i] = longint'($urandom_range(0, 80 * 65536)) - 40 * 65536;
        end
      end else if (k < 80) begin
        for (int i = 0; i < 16; i++) begin
          plan_abs[i] = longint'(signed'(rand_word()));
          plan_log[i] = longint'(signed'(rand_word()));
        end
      end

      // registers, extremes in the first phases
      case (phase % 8)
        0: pc = 16;
        1: pc = 2;
        2: pc = 0;
        3: pc = 31;
        4: pc = 1;
        5: pc = 17;
        default: pc = $urandom_range(2, 16);
      endcase
      k = $urandom_range(99);
      if (phase == 3) mz = 32'h7FFF_FFFF;
      else if (phase == 5) mz = 32'h8000_0000;
      else if (k < 75) mz = 32'(plan_abs[$urandom_range(0, 15)]);
      else mz = rand_word();
      reg_write(pwe_pkg::REG_POINT_COUNT, 32'(pc));
      reg_write(pwe_pkg::REG_MODE_ABSCISSA, mz);
      reg_write(pwe_pkg::REG_MODE_SIDE, 32'($urandom_range(1)));
      reg_write(pwe_pkg::REG_MODE_INTERIOR,
                (phase % 3 == 0) ? 32'd0 : 32'($urandom_range(1)));
      @(negedge clk);
      cfg_valid <= 1'b0;

      for (int i = 0; i < 16; i++) begin
        send_word(pwe_pkg::OP_LOAD, 4'(i), 32'(plan_abs[i]), 32'(plan_log[i]), rand_word());
        sent++;
      end

      // long output hold while the input keeps offering evals
      if (phase % 6 == 2) hold_req++;

      n_eval = $urandom_range(20, 40);
      for (int e = 0; e < n_eval; e++) begin
        k = $urandom_range(15);
        case ($urandom_range(5))
          0: qv = 32'(plan_abs[k]);
          1: qv = 32'(plan_abs[k] + 1);
          2: qv = 32'(plan_abs[k] - 1);
          3: qv = 32'(plan_abs[k] + $urandom_range(0, 65536));
          4: qv = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: qv = rand_word();
        endcase
        send_word(pwe_pkg::OP_EVAL, 4'($urandom_range(15)), rand_word(), rand_word(), qv);
        sent++;
        // sender pause until every result is back
        if (e == n_eval / 2 && phase % 5 == 1) begin
          in_quiet();
          while (envelope_q.size() != 0) @(posedge clk);
        end
      end
      in_quiet();
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("PASS piecewise_exp_envelope_eval");
    end else begin
      $display("FAIL piecewise_exp_envelope_eval");
    end
    $finish;
  end

endmodule
